### sv/lis_pkg.sv
`timescale 1ns / 1ps

package lis_pkg;

   localparam int COEF_W     = 16;
   localparam int PROD_W     = 2 * COEF_W;
   localparam int SUM_W      = PROD_W + 1;
   localparam int MAG_W      = PROD_W;
   localparam int FRAC_W     = 16;
   localparam int DVD_W      = MAG_W + FRAC_W;
   localparam int DIV_STAGES = DVD_W;
   localparam int COORD_W    = 32;

   typedef logic signed [COEF_W-1:0]  lis_coef_type;
   typedef logic signed [COORD_W-1:0] lis_coord_type;

   localparam lis_coord_type COORD_MAX = 32'sh7FFF_FFFF;
   localparam lis_coord_type COORD_MIN = 32'sh8000_0000;

   typedef struct packed {
      lis_coef_type first_a;
      lis_coef_type first_b;
      lis_coef_type first_c;
      lis_coef_type second_a;
      lis_coef_type second_b;
      lis_coef_type second_c;
   } lis_lines_type;

   typedef struct packed {
      logic parallel;
      logic neg_x;
      logic neg_y;
   } lis_meta_type;

   typedef struct packed {
      logic [MAG_W-1:0] den;
      logic [MAG_W-1:0] num_x;
      logic [MAG_W-1:0] num_y;
      lis_meta_type     meta;
   } lis_front_type;

   typedef struct packed {
      logic [MAG_W-1:0] rem;
      logic [DVD_W-1:0] dvd;
      logic [DVD_W-1:0] quo;
   } lis_lane_type;

endpackage

### sv/lis_if.sv
`timescale 1ns / 1ps

interface lis_req_if;
   import lis_pkg::*;

   logic         valid;
   logic         ready;
   lis_coef_type first_a;
   lis_coef_type first_b;
   lis_coef_type first_c;
   lis_coef_type second_a;
   lis_coef_type second_b;
   lis_coef_type second_c;

   modport source (
      output valid, first_a, first_b, first_c, second_a, second_b, second_c,
      input  ready
   );
   modport sink (
      input  valid, first_a, first_b, first_c, second_a, second_b, second_c,
      output ready
   );
endinterface

interface lis_rsp_if;
   import lis_pkg::*;

   logic          valid;
   logic          ready;
   lis_coord_type cross_x;
   lis_coord_type cross_y;
   logic          parallel;
   logic          saturated;

   modport source (
      output valid, cross_x, cross_y, parallel, saturated,
      input  ready
   );
   modport sink (
      input  valid, cross_x, cross_y, parallel, saturated,
      output ready
   );
endinterface

### sv/lis_front.sv
`timescale 1ns / 1ps

module lis_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_valid,
   input  lis_pkg::lis_lines_type in_lines,
   output logic                  out_valid,
   output lis_pkg::lis_front_type out_data
);
   import lis_pkg::*;

   // Stage A: the six coefficient products.
   logic                     va_ff;
   logic signed [PROD_W-1:0] p_a1b2_in, p_a2b1_in, p_b1c2_in, p_b2c1_in, p_c1a2_in, p_a1c2_in;
   logic signed [PROD_W-1:0] p_a1b2_ff, p_a2b1_ff, p_b1c2_ff, p_b2c1_ff, p_c1a2_ff, p_a1c2_ff;

   // Stage B: determinant and both numerators, exact.
   logic                    vb_ff;
   logic signed [SUM_W-1:0] det_in, nx_in, ny_in;
   logic signed [SUM_W-1:0] det_ff, nx_ff, ny_ff;

   // Stage C: magnitudes and signs for the unsigned divider.
   logic          vc_ff;
   lis_front_type front_in;
   lis_front_type front_ff;

   function automatic logic [MAG_W-1:0] magnitude(input logic signed [SUM_W-1:0] v);
      logic [SUM_W-1:0] m;
      m = v[SUM_W-1] ? (SUM_W'(0) - SUM_W'(v)) : SUM_W'(v);
      return m[MAG_W-1:0];
   endfunction

   assign p_a1b2_in = in_lines.first_a  * in_lines.second_b;
   assign p_a2b1_in = in_lines.second_a * in_lines.first_b;
   assign p_b1c2_in = in_lines.first_b  * in_lines.second_c;
   assign p_b2c1_in = in_lines.second_b * in_lines.first_c;
   assign p_c1a2_in = in_lines.first_c  * in_lines.second_a;
   assign p_a1c2_in = in_lines.first_a  * in_lines.second_c;

   assign det_in = {p_a1b2_ff[PROD_W-1], p_a1b2_ff} - {p_a2b1_ff[PROD_W-1], p_a2b1_ff};
   assign nx_in  = {p_b1c2_ff[PROD_W-1], p_b1c2_ff} - {p_b2c1_ff[PROD_W-1], p_b2c1_ff};
   assign ny_in  = {p_c1a2_ff[PROD_W-1], p_c1a2_ff} - {p_a1c2_ff[PROD_W-1], p_a1c2_ff};

   always_comb begin
      front_in.den           = magnitude(det_ff);
      front_in.num_x         = magnitude(nx_ff);
      front_in.num_y         = magnitude(ny_ff);
      front_in.meta.parallel = (det_ff == '0);
      front_in.meta.neg_x    = nx_ff[SUM_W-1] ^ det_ff[SUM_W-1];
      front_in.meta.neg_y    = ny_ff[SUM_W-1] ^ det_ff[SUM_W-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else if (en) begin
         va_ff <= in_valid;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_a1b2_ff <= p_a1b2_in;
         p_a2b1_ff <= p_a2b1_in;
         p_b1c2_ff <= p_b1c2_in;
         p_b2c1_ff <= p_b2c1_in;
         p_c1a2_ff <= p_c1a2_in;
         p_a1c2_ff <= p_a1c2_in;
         det_ff    <= det_in;
         nx_ff     <= nx_in;
         ny_ff     <= ny_in;
         front_ff  <= front_in;
      end
   end

   assign out_valid = vc_ff;
   assign out_data  = front_ff;

endmodule

### sv/lis_divider.sv
`timescale 1ns / 1ps

module lis_divider (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  lis_pkg::lis_front_type  in_data,
   output logic                    out_valid,
   output lis_pkg::lis_meta_type   out_meta,
   output logic [lis_pkg::DVD_W-1:0] out_quo_x,
   output logic [lis_pkg::DVD_W-1:0] out_quo_y
);
   import lis_pkg::*;

   logic         prv_valid [DIV_STAGES];
   lis_meta_type prv_meta  [DIV_STAGES];
   logic [MAG_W-1:0] prv_den [DIV_STAGES];
   lis_lane_type prv_x     [DIV_STAGES];
   lis_lane_type prv_y     [DIV_STAGES];

   lis_lane_type x_in      [DIV_STAGES];
   lis_lane_type y_in      [DIV_STAGES];

   logic         valid_ff  [DIV_STAGES];
   lis_meta_type meta_ff   [DIV_STAGES];
   logic [MAG_W-1:0] den_ff [DIV_STAGES];
   lis_lane_type x_ff      [DIV_STAGES];
   lis_lane_type y_ff      [DIV_STAGES];

   // One restoring step: bring in the next dividend bit and try a subtract.
   function automatic lis_lane_type div_step(input lis_lane_type cur,
                                             input logic [MAG_W-1:0] den);
      logic [MAG_W:0] trial;
      logic [MAG_W:0] diff;
      lis_lane_type   nxt;
      trial   = {cur.rem, cur.dvd[DVD_W-1]};
      diff    = trial - {1'b0, den};
      nxt.dvd = {cur.dvd[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, den}) begin
         nxt.rem = diff[MAG_W-1:0];
         nxt.quo = {cur.quo[DVD_W-2:0], 1'b1};
      end else begin
         nxt.rem = trial[MAG_W-1:0];
         nxt.quo = {cur.quo[DVD_W-2:0], 1'b0};
      end
      return nxt;
   endfunction

   always_comb begin
      prv_valid[0] = in_valid;
      prv_meta[0]  = in_data.meta;
      prv_den[0]   = in_data.den;
      prv_x[0].rem = '0;
      prv_x[0].dvd = {in_data.num_x, FRAC_W'(0)};
      prv_x[0].quo = '0;
      prv_y[0].rem = '0;
      prv_y[0].dvd = {in_data.num_y, FRAC_W'(0)};
      prv_y[0].quo = '0;
      for (int s = 1; s < DIV_STAGES; s++) begin
         prv_valid[s] = valid_ff[s-1];
         prv_meta[s]  = meta_ff[s-1];
         prv_den[s]   = den_ff[s-1];
         prv_x[s]     = x_ff[s-1];
         prv_y[s]     = y_ff[s-1];
      end
      for (int s = 0; s < DIV_STAGES; s++) begin
         x_in[s] = div_step(prv_x[s], prv_den[s]);
         y_in[s] = div_step(prv_y[s], prv_den[s]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            valid_ff[s] <= prv_valid[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < DIV_STAGES; s++) begin
            meta_ff[s] <= prv_meta[s];
            den_ff[s]  <= prv_den[s];
            x_ff[s]    <= x_in[s];
            y_ff[s]    <= y_in[s];
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_meta  = meta_ff[DIV_STAGES-1];
   assign out_quo_x = x_ff[DIV_STAGES-1].quo;
   assign out_quo_y = y_ff[DIV_STAGES-1].quo;

endmodule

### sv/lis_post.sv
`timescale 1ns / 1ps

module lis_post (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      en,
   input  logic                      in_valid,
   input  lis_pkg::lis_meta_type     in_meta,
   input  logic [lis_pkg::DVD_W-1:0] in_quo_x,
   input  logic [lis_pkg::DVD_W-1:0] in_quo_y,
   output logic                      out_valid,
   output lis_pkg::lis_coord_type    out_x,
   output lis_pkg::lis_coord_type    out_y,
   output logic                      out_parallel,
   output logic                      out_saturated
);
   import lis_pkg::*;

   typedef struct packed {
      lis_coord_type value;
      logic          sat;
   } lis_clamp_type;

   localparam logic [DVD_W-1:0] POS_LIMIT = DVD_W'(COORD_MAX);
   localparam logic [DVD_W-1:0] NEG_LIMIT = {{(DVD_W-COORD_W){1'b0}}, COORD_MIN};

   lis_clamp_type cx, cy;
   logic          valid_ff;
   lis_coord_type x_in, y_in, x_ff, y_ff;
   logic          par_ff, sat_in, sat_ff;

   // Apply the sign to the quotient magnitude and clamp it to 32 bits.
   function automatic lis_clamp_type clamp_coord(input logic [DVD_W-1:0] quo,
                                                 input logic neg);
      lis_clamp_type r;
      r.sat = 1'b0;
      if (neg && (quo != '0)) begin
         if (quo > NEG_LIMIT) begin
            r.sat   = 1'b1;
            r.value = COORD_MIN;
         end else begin
            r.value = COORD_W'(0) - quo[COORD_W-1:0];
         end
      end else if (quo > POS_LIMIT) begin
         r.sat   = 1'b1;
         r.value = COORD_MAX;
      end else begin
         r.value = quo[COORD_W-1:0];
      end
      return r;
   endfunction

   assign cx = clamp_coord(in_quo_x, in_meta.neg_x);
   assign cy = clamp_coord(in_quo_y, in_meta.neg_y);

   always_comb begin
      if (in_meta.parallel) begin
         x_in   = '0;
         y_in   = '0;
         sat_in = 1'b0;
      end else begin
         x_in   = cx.value;
         y_in   = cy.value;
         sat_in = cx.sat | cy.sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         par_ff <= in_meta.parallel;
         sat_ff <= sat_in;
      end
   end

   assign out_valid     = valid_ff;
   assign out_x         = x_ff;
   assign out_y         = y_ff;
   assign out_parallel  = par_ff;
   assign out_saturated = sat_ff;

endmodule

### sv/line_intersection_solver_core.sv
`timescale 1ns / 1ps
//
// Channel   Direction  Beat contents
// --------  ---------  ----------------------------------------------------------
// req_bus   in         first_a/b/c, second_a/b/c: two lines a*x+b*y+c=0, Q8.8
// rsp_bus   out        cross_x, cross_y (Q16.16, saturated), parallel, saturated
//
// One beat is accepted per cycle unless stalled, and one result beat leaves per
// accepted beat, in order. Stages: three in front (products, differences,
// magnitudes), 48 restoring divider stages that each settle one quotient bit
// of the 48-bit scaled numerator, and the clamp/output register.
// Reset is synchronous and clears only the valid bits; no clearing pass.
// The whole pipeline advances together: it holds while a result beat waits at
// the output and rsp_bus.ready is low, so nothing is dropped or repeated.
//
module line_intersection_solver_core (
   input  logic      clock,
   input  logic      reset,
   lis_req_if.sink   req_bus,
   lis_rsp_if.source rsp_bus
);
   import lis_pkg::*;

   logic          en;
   lis_lines_type lines;

   logic          front_valid;
   lis_front_type front_data;

   logic             div_valid;
   lis_meta_type     div_meta;
   logic [DVD_W-1:0] div_quo_x;
   logic [DVD_W-1:0] div_quo_y;

   logic post_valid;

   // Every stage moves when the output register is empty or being drained.
   // Bubbles inside the pipe are carried along as cleared valid bits.
   assign en            = !post_valid || rsp_bus.ready;
   assign req_bus.ready = en;

   always_comb begin
      lines.first_a  = req_bus.first_a;
      lines.first_b  = req_bus.first_b;
      lines.first_c  = req_bus.first_c;
      lines.second_a = req_bus.second_a;
      lines.second_b = req_bus.second_b;
      lines.second_c = req_bus.second_c;
   end

   // Products, determinant and numerators, then unsigned magnitudes with the
   // quotient signs and the parallel flag on the side.
   lis_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_bus.valid),
      .in_lines  (lines),
      .out_valid (front_valid),
      .out_data  (front_data)
   );

   // Both coordinates share the divisor; each lane divides its numerator,
   // scaled by 2^16, one bit per stage.
   lis_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (front_valid),
      .in_data   (front_data),
      .out_valid (div_valid),
      .out_meta  (div_meta),
      .out_quo_x (div_quo_x),
      .out_quo_y (div_quo_y)
   );

   // Signs, clamping and the parallel override, into the output register.
   lis_post u_post (
      .clock         (clock),
      .reset         (reset),
      .en            (en),
      .in_valid      (div_valid),
      .in_meta       (div_meta),
      .in_quo_x      (div_quo_x),
      .in_quo_y      (div_quo_y),
      .out_valid     (post_valid),
      .out_x         (rsp_bus.cross_x),
      .out_y         (rsp_bus.cross_y),
      .out_parallel  (rsp_bus.parallel),
      .out_saturated (rsp_bus.saturated)
   );

   assign rsp_bus.valid = post_valid;

endmodule

### sv/lis_checker.sv
`timescale 1ns / 1ps

module lis_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input lis_pkg::lis_coord_type cross_x,
   input lis_pkg::lis_coord_type cross_y,
   input logic                   parallel,
   input logic                   saturated
);
   import lis_pkg::*;

   // Parallel lines report the origin and never a clamp.
   a_parallel_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && parallel |-> cross_x == '0 && cross_y == '0 && !saturated)
      else $error("parallel result carries nonzero coordinates or clamp");

   // A clamp leaves at least one coordinate at a range limit.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && saturated |->
         cross_x == COORD_MAX || cross_x == COORD_MIN ||
         cross_y == COORD_MAX || cross_y == COORD_MIN)
      else $error("saturated result has no coordinate at a limit");

   // With no result waiting the pipeline is free to take a beat.
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled while output is empty");

   // Reset empties the output register.
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled result beat holds its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(cross_x) && $stable(cross_y) &&
         $stable(parallel) && $stable(saturated))
      else $error("stalled result beat changed");

endmodule

bind line_intersection_solver_core lis_checker u_lis_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .cross_x   (rsp_bus.cross_x),
   .cross_y   (rsp_bus.cross_y),
   .parallel  (rsp_bus.parallel),
   .saturated (rsp_bus.saturated)
);
